>>> rtl/mttg_pkg.sv
// Package for the multichannel three-tone generator: sizes, register indexes,
// sequencer states and the quarter-wave sine table builder.
// Depends on nothing; used by multichannel_three_tone_generator.
package mttg_pkg;

    localparam int MAX_CHANNELS    = 16;
    localparam int MAX_EPOCH       = 1024;
    localparam int SINE_INDEX_BITS = 10;

    localparam int CHAN_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int OFFSET_W = (MAX_EPOCH > 1) ? $clog2(MAX_EPOCH) : 1;
    localparam int TOTAL_W  = $clog2(MAX_CHANNELS + 1);
    localparam int LEN_W    = $clog2(MAX_EPOCH + 1);

    localparam int ROM_SIZE = 1 << SINE_INDEX_BITS;
    localparam int ROM_W    = 15;
    localparam int ADDR_W   = SINE_INDEX_BITS + 1;

    localparam int RATE_W      = 21;
    localparam int TOTAL_REG_W = 5;
    localparam int LEN_REG_W   = 11;
    localparam int STEP_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int STAMP_W     = 64;
    localparam int VALUE_W     = 17;
    localparam int CHAN_OUT_W  = 4;

    localparam int DIV_STEPS   = STAMP_W;
    localparam int PHASE_STEPS = COUNT_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int TONES       = 3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_TOTAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EPOCH_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_A_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_B_STEP   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_C_STEP   = 3'd5;

    localparam logic [RATE_W-1:0]      RATE_RESET   = 21'd512;
    localparam logic [TOTAL_REG_W-1:0] TOTAL_RESET  = 5'd4;
    localparam logic [LEN_REG_W-1:0]   LEN_RESET    = 11'd32;
    localparam logic [STEP_W-1:0]      STEP_A_RESET = 32'd16421577;
    localparam logic [STEP_W-1:0]      STEP_B_RESET = 32'd6007894;
    localparam logic [STEP_W-1:0]      STEP_C_RESET = 32'd90518939;

    localparam int OUT_FIELDS_W = CHAN_OUT_W + COUNT_W + VALUE_W + 2 * STAMP_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_DATA_W    = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } gen_state_t;

    typedef struct packed {
        logic in_ready;
        logic load_en;
        logic run_en;
        logic finish_en;
    } seq_ctrl_t;

    typedef logic [ROM_W-1:0] sine_rom_t [0:ROM_SIZE];

    // pi/2 in Q30 and the Taylor denominators (2j)(2j+1) for j = 1..8.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};
    localparam logic [63:0] SINE_ONE = 64'd16384;

    // Round(16384 * sin(pi*k/(2N))) by a Q30 series, ties rounded up.
    function automatic logic [ROM_W-1:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * 64'(k)) >> SINE_INDEX_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int j = 1; j <= 8; j++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[j];
            if (j % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        r = (acc * SINE_ONE + (64'd1 << 29)) >> 30;
        if (r > SINE_ONE) begin
            r = SINE_ONE;
        end
        return ROM_W'(r);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= ROM_SIZE; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

endpackage

>>> rtl/multichannel_three_tone_generator.sv
// Multichannel three-tone test-signal generator, one sample per accepted word
// with advance set. A request word is taken only in IDLE, so the next request
// waits while the last one goes through LOAD, the 64-step bit-serial timestamp
// dividers in RUN and FINISH. Requests with advance low give no result.
// Reset (aresetn low, synchronous) restores the register defaults and zeroes
// the counters; the sine table is a constant ROM, so no clearing pass exists.
module multichannel_three_tone_generator import mttg_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Request channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [0] advance, [7:1] zero
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] channel_index, [35:4] sample_number, [52:36] sample_value,
    // [116:53] epoch_start_time, [180:117] epoch_end_time, [183:181] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,   // epoch_last
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; software must only
    // write while the generator is idle, which the block does not enforce.
    // ------------------------------------------------------------------
    logic [RATE_W-1:0]      sample_rate_reg;
    logic [TOTAL_REG_W-1:0] channel_total_reg;
    logic [LEN_REG_W-1:0]   epoch_length_reg;
    logic [STEP_W-1:0]      tone_step_reg [TONES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg   <= RATE_RESET;
            channel_total_reg <= TOTAL_RESET;
            epoch_length_reg  <= LEN_RESET;
            tone_step_reg[0]  <= STEP_A_RESET;
            tone_step_reg[1]  <= STEP_B_RESET;
            tone_step_reg[2]  <= STEP_C_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_CHANNEL_TOTAL: channel_total_reg <= cfg_data[TOTAL_REG_W-1:0];
                CFG_EPOCH_LENGTH:  epoch_length_reg  <= cfg_data[LEN_REG_W-1:0];
                CFG_TONE_A_STEP:   tone_step_reg[0]  <= cfg_data[STEP_W-1:0];
                CFG_TONE_B_STEP:   tone_step_reg[1]  <= cfg_data[STEP_W-1:0];
                CFG_TONE_C_STEP:   tone_step_reg[2]  <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a request word, LOAD scales the tone steps by
    // the channel index plus one, RUN does 64 serial steps, FINISH hands the result
    // to the output register once that register is free.
    // ------------------------------------------------------------------
    gen_state_t state_reg, state_next;
    seq_ctrl_t  ctrl;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  in_accept;
    logic                  advance;

    assign advance   = s_tdata[0];
    assign in_accept = s_tvalid && ctrl.in_ready;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && advance) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_RUN;
            ST_RUN: begin
                if (step_cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:   ctrl.in_ready  = 1'b1;
            ST_LOAD:   ctrl.load_en   = 1'b1;
            ST_RUN:    ctrl.run_en    = 1'b1;
            ST_FINISH: ctrl.finish_en = out_free;
            default: ;
        endcase
    end

    assign s_tready = ctrl.in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl.load_en) begin
                step_cnt_reg <= '0;
            end else if (ctrl.run_en) begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Buffer-order counters: offset within the epoch runs fastest, then
    // the channel; the epoch base moves on after the last channel. Bounds
    // are clamped to one and to the maximum sizes.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]  epoch_base_reg, epoch_base_next;
    logic [CHAN_W-1:0]   channel_reg, channel_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [TOTAL_W-1:0]  total;
    logic [LEN_W-1:0]    len;
    logic                last_off;
    logic                last_chan;
    logic [COUNT_W-1:0]  sample_count;
    logic [COUNT_W-1:0]  end_count;

    always_comb begin
        if (channel_total_reg == '0) begin
            total = TOTAL_W'(1);
        end else if (32'(channel_total_reg) > MAX_CHANNELS) begin
            total = TOTAL_W'(MAX_CHANNELS);
        end else begin
            total = TOTAL_W'(channel_total_reg);
        end
        if (epoch_length_reg == '0) begin
            len = LEN_W'(1);
        end else if (32'(epoch_length_reg) > MAX_EPOCH) begin
            len = LEN_W'(MAX_EPOCH);
        end else begin
            len = LEN_W'(epoch_length_reg);
        end
    end

    assign last_off     = (32'(offset_reg) + 32'd1) >= 32'(len);
    assign last_chan    = (32'(channel_reg) + 32'd1) >= 32'(total);
    assign sample_count = epoch_base_reg + COUNT_W'(offset_reg);
    assign end_count    = epoch_base_reg + COUNT_W'(len);

    always_comb begin
        epoch_base_next = epoch_base_reg;
        channel_next    = channel_reg;
        offset_next     = offset_reg;
        if (in_accept && advance) begin
            if (last_off) begin
                offset_next = '0;
                if (last_chan) begin
                    channel_next    = '0;
                    epoch_base_next = end_count;
                end else begin
                    channel_next = channel_reg + 1'b1;
                end
            end else begin
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_base_reg <= '0;
            channel_reg    <= '0;
            offset_reg     <= '0;
        end else begin
            epoch_base_reg <= epoch_base_next;
            channel_reg    <= channel_next;
            offset_reg     <= offset_next;
        end
    end

    // ------------------------------------------------------------------
    // Per-sample datapath.
    // Phase: phase_k = n * ((c+1) * step_k), formed MSB first over the bits
    // of n at the start of RUN. Sines: the three phases then rotate through
    // one ROM read port and are summed.
    // Timestamps: two restoring dividers, one quotient bit per cycle through
    // RUN; a zero rate yields all ones by itself.
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]  chan_cap_reg;
    logic [COUNT_W-1:0] n_cap_reg;
    logic [COUNT_W-1:0] n_shift_reg;
    logic               last_cap_reg;
    logic [STEP_W-1:0]  scaled_step_reg [TONES];
    logic [STEP_W-1:0]  phase_reg [TONES];
    logic [STAMP_W-1:0] start_num_reg, end_num_reg;
    logic [RATE_W-1:0]  start_rem_reg, end_rem_reg;
    logic [RATE_W:0]    start_trial, end_trial;
    logic               start_bit, end_bit;
    logic [ADDR_W-1:0]  rom_addr;
    logic [ROM_W-1:0]   rom_data_reg;
    logic               rom_neg_reg;
    logic               rom_valid_reg;
    logic               rom_issue;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] rom_term;

    assign start_trial = {start_rem_reg, start_num_reg[STAMP_W-1]};
    assign end_trial   = {end_rem_reg, end_num_reg[STAMP_W-1]};
    assign start_bit   = start_trial >= {1'b0, sample_rate_reg};
    assign end_bit     = end_trial >= {1'b0, sample_rate_reg};

    // Odd quadrants read the table mirrored; the upper half is negated.
    assign rom_addr = phase_reg[0][30] ?
                      ADDR_W'(ROM_SIZE) - ADDR_W'(phase_reg[0][29 -: SINE_INDEX_BITS]) :
                      ADDR_W'(phase_reg[0][29 -: SINE_INDEX_BITS]);

    assign rom_issue = ctrl.run_en &&
                       (step_cnt_reg >= STEP_CNT_W'(PHASE_STEPS)) &&
                       (step_cnt_reg < STEP_CNT_W'(PHASE_STEPS + TONES));

    assign rom_term = rom_neg_reg ? -$signed({2'b00, rom_data_reg}) :
                                    $signed({2'b00, rom_data_reg});

    always_ff @(posedge aclk) begin
        if (in_accept && advance) begin
            chan_cap_reg  <= channel_reg;
            n_cap_reg     <= sample_count;
            n_shift_reg   <= sample_count;
            last_cap_reg  <= last_off && last_chan;
            start_num_reg <= {epoch_base_reg, 32'd0};
            end_num_reg   <= {end_count, 32'd0};
            start_rem_reg <= '0;
            end_rem_reg   <= '0;
        end

        if (ctrl.load_en) begin
            for (int k = 0; k < TONES; k++) begin
                scaled_step_reg[k] <= STEP_W'(tone_step_reg[k] *
                                              (CHAN_W+1)'({1'b0, chan_cap_reg} + 1'b1));
                phase_reg[k] <= '0;
            end
            value_reg <= '0;
        end

        if (ctrl.run_en) begin
            start_num_reg <= {start_num_reg[STAMP_W-2:0], start_bit};
            end_num_reg   <= {end_num_reg[STAMP_W-2:0], end_bit};
            start_rem_reg <= start_bit ? RATE_W'(start_trial - {1'b0, sample_rate_reg}) :
                                         start_trial[RATE_W-1:0];
            end_rem_reg   <= end_bit ? RATE_W'(end_trial - {1'b0, sample_rate_reg}) :
                                       end_trial[RATE_W-1:0];

            if (step_cnt_reg < STEP_CNT_W'(PHASE_STEPS)) begin
                n_shift_reg <= {n_shift_reg[COUNT_W-2:0], 1'b0};
                for (int k = 0; k < TONES; k++) begin
                    phase_reg[k] <= {phase_reg[k][STEP_W-2:0], 1'b0} +
                                    (n_shift_reg[COUNT_W-1] ? scaled_step_reg[k] : '0);
                end
            end
        end

        // One table read per cycle; the phases rotate toward the read port.
        rom_valid_reg <= rom_issue;
        if (rom_issue) begin
            rom_data_reg <= SINE_ROM[rom_addr];
            rom_neg_reg  <= phase_reg[0][31];
            for (int k = 0; k < TONES - 1; k++) begin
                phase_reg[k] <= phase_reg[k+1];
            end
        end
        if (rom_valid_reg) begin
            value_reg <= value_reg + rom_term;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one finished word while the sequencer may
    // already take the next request.
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.finish_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish_en) begin
            out_data_reg <= OUT_DATA_W'({end_num_reg, start_num_reg, value_reg,
                                         n_cap_reg, CHAN_OUT_W'(chan_cap_reg)});
            out_last_reg <= last_cap_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
